FILE: rtl/lrupr_pkg.sv
// Package for the LRU page replacement block.
// Holds the result word type, the link flags passed between frame cells and register codes.
// Depends on nothing; used by every module in rtl.
package lrupr_pkg;

    localparam int PAGE_PORT_W = 16;
    localparam int FAULT_W     = 16;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;
    localparam int FIU_W       = 4;

    localparam logic [FIU_W-1:0]   FIU_RESET = 4'd8;
    localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

    // Register index decoded from paddr[2].
    localparam logic REG_FRAMES_IN_USE = 1'b0;

    typedef logic [PAGE_PORT_W-1:0] page_port_t;
    typedef logic [FAULT_W-1:0]     fault_t;

    typedef struct packed {
        logic hit_seen;
        logic empty_seen;
    } link_t;

    typedef struct packed {
        logic       hit;
        logic       evicted_valid;
        page_port_t evicted_page;
        fault_t     fault_count;
    } res_t;

endpackage

FILE: rtl/lrupr_cell.sv
// One frame cell of the LRU stack: holds a page and its valid bit.
// Loads from its left neighbor when the stack shifts; passes search flags to the right.
// Depends on lrupr_pkg.
module lrupr_cell
    import lrupr_pkg::*;
#(
    parameter int PW = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load_en,
    input  logic          hit_any,
    input  logic          win,
    input  logic          last,
    input  logic [PW-1:0] ref_page,
    input  logic [PW-1:0] left_page,
    input  logic          left_valid,
    input  link_t         link_in,
    input  logic [PW-1:0] ev_in,
    output link_t         link_out,
    output logic [PW-1:0] ev_out,
    output logic [PW-1:0] page,
    output logic          valid
);

    logic [PW-1:0] page_reg;
    logic [PW-1:0] page_next;
    logic          valid_reg;
    logic          valid_next;
    logic          shift;

    always_comb
    begin
        link_out.hit_seen   = link_in.hit_seen | (win & valid_reg & (page_reg == ref_page));
        link_out.empty_seen = link_in.empty_seen | (win & ~valid_reg);
        ev_out              = ev_in | (page_reg & {PW{last}});
        shift = load_en & win & (hit_any ? ~link_in.hit_seen : ~link_in.empty_seen);
        page_next  = shift ? left_page : page_reg;
        valid_next = shift ? left_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

    assign page  = page_reg;
    assign valid = valid_reg;

endmodule

FILE: rtl/lrupr_out.sv
// Output register with a skid stage for the result word.
// Lets a new word be taken while the previous one waits on a stalled receiver.
// Depends on lrupr_pkg.
module lrupr_out
    import lrupr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic res_valid,
    input  res_t res,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    output res_t out_res
);

    logic out_valid_reg;
    logic out_valid_next;
    res_t out_res_reg;
    res_t out_res_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    res_t skid_res_reg;
    res_t skid_res_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        if (out_valid_reg && out_stall)
        begin
            if (res_valid)
            begin
                skid_valid_next = 1'b1;
                skid_res_next   = res;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_res_next    = skid_res_reg;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_res_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held while output register is empty");

    a_skid_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && out_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("word taken during output stall was not kept in skid stage");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid word did not move to output register");
`endif

endmodule

FILE: rtl/lru_page_replacement.sv
// Top level of the LRU page replacement block: a chain of frame cells kept in recency order,
// the frames_in_use register on an APB-style port, the fault counter and the output stage.
// Depends on lrupr_pkg, lrupr_cell and lrupr_out.
//
// Usage: each input word on (in_valid, in_stall, page_id) is one page reference. It is
// accepted when in_valid is high and in_stall is low. One result word comes out on
// (out_valid, out_stall) with hit, evicted_valid, evicted_page and fault_count, and is
// taken when out_valid is high and out_stall is low.
// The result word of an accepted reference is registered in the output or skid stage.
// Throughput is one reference per cycle while in_stall is low; the whole cell chain compares
// and shifts in the same cycle, so the next reference sees the updated recency order.
// When the receiver stalls, one more word is taken into a skid stage and then in_stall rises
// until the receiver takes the waiting word.
// Reset empties all frames, clears the fault counter and sets frames_in_use to 8 (bounded by
// MAX_FRAMES). Write frames_in_use only while the block is idle; the block does not check.
module lru_page_replacement
    import lrupr_pkg::*;
#(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PAGE_PORT_W-1:0] page_id,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  hit,
    output logic                  evicted_valid,
    output logic [PAGE_PORT_W-1:0] evicted_page,
    output logic [FAULT_W-1:0]    fault_count,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int PW    = (PAGE_BITS < PAGE_PORT_W) ? PAGE_BITS : PAGE_PORT_W;
    localparam int CL    = $clog2(MAX_FRAMES + 1);
    localparam int CW    = (CL > FIU_W) ? CL : FIU_W;

    logic [FIU_W-1:0]      frames_in_use_reg;
    logic [FIU_W-1:0]      frames_in_use_next;
    fault_t                fault_cnt_reg;
    fault_t                fault_cnt_next;
    logic [CW-1:0]         fiu_ext;
    logic [CW-1:0]         eff_frames;
    logic                  accept;
    logic                  miss;
    logic [PW-1:0]         ref_page;
    logic [MAX_FRAMES-1:0] win;
    logic [MAX_FRAMES-1:0] last;
    logic [MAX_FRAMES-1:0] valid_vec;
    logic [PW-1:0]         cell_page [MAX_FRAMES];
    link_t                 link      [MAX_FRAMES+1];
    logic [PW-1:0]         ev_chain  [MAX_FRAMES+1];
    res_t                  res;
    res_t                  out_res;

    // Configuration port.
    always_comb
    begin
        frames_in_use_next = frames_in_use_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_FRAMES_IN_USE))
        begin
            frames_in_use_next = pwdata[FIU_W-1:0];
        end
        prdata = (paddr[2] == REG_FRAMES_IN_USE) ? CFG_DATA_W'(frames_in_use_reg) : '0;
    end

    assign pready = 1'b1;

    always_comb
    begin
        fiu_ext = CW'(frames_in_use_reg);
        if (fiu_ext == '0)
        begin
            eff_frames = CW'(1);
        end
        else if (fiu_ext > CW'(MAX_FRAMES))
        begin
            eff_frames = CW'(MAX_FRAMES);
        end
        else
        begin
            eff_frames = fiu_ext;
        end
    end

    assign accept   = in_valid & ~in_stall;
    assign ref_page = page_id[PW-1:0];
    assign link[0]  = '0;
    assign ev_chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_FRAMES; gi++)
        begin : g_cell
            logic [PW-1:0] left_page;
            logic          left_valid;

            assign win[gi] = (CW'(gi) < eff_frames);

            if (gi == MAX_FRAMES - 1)
            begin : g_end
                assign last[gi] = win[gi];
            end
            else
            begin : g_mid
                assign last[gi] = win[gi] & ~win[gi+1];
            end

            if (gi == 0)
            begin : g_head
                assign left_page  = ref_page;
                assign left_valid = 1'b1;
            end
            else
            begin : g_body
                assign left_page  = cell_page[gi-1];
                assign left_valid = valid_vec[gi-1];
            end

            lrupr_cell #(
                .PW (PW)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .load_en    (accept),
                .hit_any    (link[MAX_FRAMES].hit_seen),
                .win        (win[gi]),
                .last       (last[gi]),
                .ref_page   (ref_page),
                .left_page  (left_page),
                .left_valid (left_valid),
                .link_in    (link[gi]),
                .ev_in      (ev_chain[gi]),
                .link_out   (link[gi+1]),
                .ev_out     (ev_chain[gi+1]),
                .page       (cell_page[gi]),
                .valid      (valid_vec[gi])
            );
        end
    endgenerate

    // Result word and fault counter.
    always_comb
    begin
        miss              = ~link[MAX_FRAMES].hit_seen;
        res.hit           = link[MAX_FRAMES].hit_seen;
        res.evicted_valid = miss & ~link[MAX_FRAMES].empty_seen;
        res.evicted_page  = res.evicted_valid ? page_port_t'(ev_chain[MAX_FRAMES]) : '0;
        if (miss && (fault_cnt_reg != FAULT_MAX))
        begin
            res.fault_count = fault_cnt_reg + fault_t'(1);
        end
        else
        begin
            res.fault_count = fault_cnt_reg;
        end
        fault_cnt_next = accept ? res.fault_count : fault_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= FIU_RESET;
            fault_cnt_reg     <= '0;
        end
        else
        begin
            frames_in_use_reg <= frames_in_use_next;
            fault_cnt_reg     <= fault_cnt_next;
        end
    end

    lrupr_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (accept),
        .res       (res),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign hit           = out_res.hit;
    assign evicted_valid = out_res.evicted_valid;
    assign evicted_page  = out_res.evicted_page;
    assign fault_count   = out_res.fault_count;

`ifndef NO_ASSERTIONS
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & ~((valid_vec << 1) | MAX_FRAMES'(1))) == '0)
        else $error("occupied frames are not contiguous from the most recent end");

    a_head_update: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (valid_vec[0] && (cell_page[0] == $past(ref_page))))
        else $error("referenced page did not become most recent");

    a_fault_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (fault_cnt_reg >= $past(fault_cnt_reg)))
        else $error("fault counter went backward");
`endif

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the LRU page replacement block lru_page_replacement.
// Runs a directed table, random phases, a short single-frame fault burst and a last random run.
// Words are checked against typed rows or a recency-order predictor. Depends on rtl/lrupr_pkg.sv.
`timescale 1ns / 100ps

module tb_top;
    import lrupr_pkg::*;

    localparam int NUM_FRAMES = 8;
    localparam logic REG_SPARE = 1'b1;

    typedef enum logic [1:0] {OP_REF, OP_CFG, OP_BADREG} plan_op_t;

    typedef struct {
        plan_op_t    op;
        logic [31:0] arg;
        bit          typed;
        res_t        want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [PAGE_PORT_W-1:0] page_id;
    logic                  out_valid;
    logic                  out_stall;
    logic                  hit;
    logic                  evicted_valid;
    logic [PAGE_PORT_W-1:0] evicted_page;
    logic [FAULT_W-1:0]    fault_count;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    page_port_t frame_pg [NUM_FRAMES];
    bit         frame_vld [NUM_FRAMES];
    fault_t     fault_tally;
    logic [3:0] frames_reg;
    res_t       pending_results [$];
    int         n_errors;
    bit         rx_calm;
    bit         long_hold_req;

    lru_page_replacement u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page_id       (page_id),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic flag_error(input string msg);
        $display("ERROR %0t: %0s", $time, msg);
        n_errors++;
    endtask

    // Searches the active window, moves the page to the most recent frame and counts faults.
    function automatic res_t lru_lookup(input page_port_t pg);
        int   n;
        int   hit_at;
        int   empty_at;
        int   pos;
        int   i;
        res_t r;
        n = (frames_reg == 4'd0) ? 1 : ((frames_reg > NUM_FRAMES) ? NUM_FRAMES : frames_reg);
        hit_at = n;
        empty_at = n;
        r = '0;
        for (i = 0; i < n; i++)
        begin
            if (frame_vld[i] && frame_pg[i] == pg && hit_at == n)
                hit_at = i;
            if (!frame_vld[i] && empty_at == n)
                empty_at = i;
        end
        if (hit_at < n)
        begin
            r.hit = 1'b1;
            pos = hit_at;
        end
        else
        begin
            if (empty_at < n)
                pos = empty_at;
            else
            begin
                pos = n - 1;
                r.evicted_valid = 1'b1;
                r.evicted_page = frame_pg[n - 1];
            end
            if (fault_tally != 16'hFFFF)
                fault_tally++;
        end
        for (i = pos; i > 0; i--)
        begin
            frame_pg[i] = frame_pg[i - 1];
            frame_vld[i] = frame_vld[i - 1];
        end
        frame_pg[0] = pg;
        frame_vld[0] = 1'b1;
        r.fault_count = fault_tally;
        return r;
    endfunction

    task automatic send_ref(input page_port_t pg, input int gap, input bit typed, input res_t want);
        res_t r;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        page_id <= pg;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        r = lru_lookup(pg);
        pending_results.push_back(typed ? want : r);
    endtask

    task automatic idle_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] data);
        idle_until_drained();
        repeat (2) @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        if (idx == REG_FRAMES_IN_USE)
            frames_reg = data[3:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic reg_readback();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {REG_FRAMES_IN_USE, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        if (prdata !== {28'd0, frames_reg})
            flag_error($sformatf("frames_in_use read %0h, want %0h", prdata, frames_reg));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic take_result();
        res_t want;
        if (pending_results.size() == 0)
        begin
            flag_error("result word with nothing pending");
            return;
        end
        want = pending_results.pop_front();
        if (hit !== want.hit)
            flag_error($sformatf("hit %0b, want %0b", hit, want.hit));
        if (evicted_valid !== want.evicted_valid)
            flag_error($sformatf("evicted_valid %0b, want %0b", evicted_valid,
                                 want.evicted_valid));
        if (evicted_page !== want.evicted_page)
            flag_error($sformatf("evicted_page %0h, want %0h", evicted_page,
                                 want.evicted_page));
        if (fault_count !== want.fault_count)
            flag_error($sformatf("fault_count %0d, want %0d", fault_count, want.fault_count));
    endtask

    function automatic plan_row_t mk_row(input plan_op_t op, input logic [31:0] arg,
                                         input bit typed, input logic h, input logic ev,
                                         input logic [15:0] evp, input logic [15:0] fc);
        plan_row_t p;
        p.op = op;
        p.arg = arg;
        p.typed = typed;
        p.want.hit = h;
        p.want.evicted_valid = ev;
        p.want.evicted_page = evp;
        p.want.fault_count = fc;
        return p;
    endfunction

    // The receiver raises out_stall for a random hold before each word unless rx_calm is set; one long hold on request.
    initial
    begin : receiver
        int wait_c;
        out_stall = 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            wait_c = rx_calm ? 0 : $urandom_range(0, 15);
            if (long_hold_req)
            begin
                wait_c = 60;
                long_hold_req = 1'b0;
            end
            if (wait_c > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (wait_c - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            take_result();
        end
    end

    initial
    begin : stimulus
        plan_row_t  plan [$];
        page_port_t pool [12];
        page_port_t pg;
        page_port_t pa;
        logic [3:0] phase_cfg [6];
        logic [3:0] cfg_val;
        logic [31:0] data;
        res_t       no_want;
        int         eff;
        int         ph;
        int         k;
        bit         quick_tx;

        in_valid = 1'b0;
        page_id = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        n_errors = 0;
        rx_calm = 1'b0;
        long_hold_req = 1'b0;
        no_want = '0;
        fault_tally = '0;
        frames_reg = FIU_RESET;
        for (k = 0; k < NUM_FRAMES; k++)
        begin
            frame_pg[k] = '0;
            frame_vld[k] = 1'b0;
        end

        // Directed part: empty frames after reset, window limits, duplicates outside the window.
        plan.push_back(mk_row(OP_REF, 32'h0000, 1'b1, 1'b0, 1'b0, 16'h0000, 16'd1));
        plan.push_back(mk_row(OP_REF, 32'hFFFF, 1'b1, 1'b0, 1'b0, 16'h0000, 16'd2));
        plan.push_back(mk_row(OP_REF, 32'h0000, 1'b1, 1'b1, 1'b0, 16'h0000, 16'd2));
        plan.push_back(mk_row(OP_CFG, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));
        plan.push_back(mk_row(OP_REF, 32'hFFFF, 1'b1, 1'b0, 1'b1, 16'h0000, 16'd3));
        plan.push_back(mk_row(OP_REF, 32'hAAAA, 1'b1, 1'b0, 1'b1, 16'hFFFF, 16'd4));
        plan.push_back(mk_row(OP_REF, 32'hAAAA, 1'b1, 1'b1, 1'b0, 16'h0000, 16'd4));
        plan.push_back(mk_row(OP_BADREG, 32'h0000_0003, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));
        plan.push_back(mk_row(OP_REF, 32'h5555, 1'b1, 1'b0, 1'b1, 16'hAAAA, 16'd5));
        plan.push_back(mk_row(OP_CFG, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));
        plan.push_back(mk_row(OP_REF, 32'hFFFF, 1'b1, 1'b1, 1'b0, 16'h0000, 16'd5));
        for (k = 1; k <= 7; k++)
            plan.push_back(mk_row(OP_REF, k, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));
        plan.push_back(mk_row(OP_CFG, 32'h0000_0002, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));
        plan.push_back(mk_row(OP_REF, 32'h0001, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));
        plan.push_back(mk_row(OP_CFG, 32'h0000_0008, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));
        plan.push_back(mk_row(OP_REF, 32'h0001, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));
        plan.push_back(mk_row(OP_REF, 32'hFFFF, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));
        plan.push_back(mk_row(OP_REF, 32'h8009, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));
        plan.push_back(mk_row(OP_REF, 32'h0001, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));
        plan.push_back(mk_row(OP_REF, 32'h8009, 1'b0, 1'b0, 1'b0, 16'h0, 16'h0));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        reg_readback();

        foreach (plan[i])
        begin
            case (plan[i].op)
                OP_REF:
                    send_ref(plan[i].arg[15:0], $urandom_range(0, 3), plan[i].typed,
                             plan[i].want);
                OP_CFG:
                begin
                    reg_write(REG_FRAMES_IN_USE, plan[i].arg);
                    reg_readback();
                end
                default:
                begin
                    reg_write(REG_SPARE, plan[i].arg);
                    reg_readback();
                end
            endcase
        end

        // Random phases, each under its own window size.
        phase_cfg[0] = 4'd1;
        phase_cfg[1] = 4'd8;
        phase_cfg[2] = 4'd0;
        phase_cfg[3] = 4'd15;
        phase_cfg[4] = 4'd2;
        phase_cfg[5] = 4'd5;
        for (ph = 0; ph < 8; ph++)
        begin
            cfg_val = (ph < 6) ? phase_cfg[ph] : 4'($urandom_range(0, 15));
            data = $urandom;
            data[3:0] = cfg_val;
            reg_write(REG_FRAMES_IN_USE, data);
            reg_readback();
            if (ph == 2 || ph == 5)
            begin
                reg_write(REG_SPARE, $urandom);
                reg_readback();
            end
            eff = (cfg_val == 4'd0) ? 1 : ((cfg_val > NUM_FRAMES) ? NUM_FRAMES : cfg_val);
            for (k = 0; k < 12; k++)
                pool[k] = page_port_t'($urandom);
            quick_tx = (ph == 3 || ph == 5);
            rx_calm = (ph == 5);
            if (ph == 3)
                long_hold_req = 1'b1;
            for (k = 0; k < 160; k++)
            begin
                if (ph == 4 && k == 80)
                    idle_until_drained();
                if ($urandom_range(0, 99) < 85)
                    pg = pool[$urandom_range(0, eff + 3)];
                else
                    pg = page_port_t'($urandom);
                send_ref(pg, quick_tx ? 0 : $urandom_range(0, 15), 1'b0, no_want);
            end
        end

        // Alternating two pages in a single frame faults on every word.
        reg_write(REG_FRAMES_IN_USE, 32'd1);
        rx_calm = 1'b1;
        pa = page_port_t'($urandom);
        for (k = 0; k < 60; k++)
            send_ref(k[0] ? pa : ~pa, 0, 1'b0, no_want);
        rx_calm = 1'b0;
        reg_write(REG_FRAMES_IN_USE, 32'd8);
        for (k = 0; k < 30; k++)
            send_ref(page_port_t'($urandom_range(0, 7)), $urandom_range(0, 15), 1'b0, no_want);

        idle_until_drained();
        repeat (10) @(posedge clk);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
